/* rtl/wavhp_pkg.sv */
// Package for the WAV header parser: parse phases, result kinds, error codes,
// the result record and the tag character lookups. No dependencies.
package wavhp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SCAN,
      PH_TA,
      PH_SIZE,
      PH_DATA,
      PH_DONE,
      PH_ERROR
   } phase_type;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NOT_RIFF = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
   localparam logic [2:0] ERR_NOT_FMT  = 3'd2;
   localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
   localparam logic [2:0] ERR_NO_TA    = 3'd4;

   localparam logic [7:0] CHAR_D = 8'h64;
   localparam logic [7:0] CHAR_A = 8'h61;

   // Header byte offsets of interest
   localparam logic [5:0] POS_FMT_LO  = 6'd20;
   localparam logic [5:0] POS_FMT_HI  = 6'd21;
   localparam logic [5:0] POS_CH_LO   = 6'd22;
   localparam logic [5:0] POS_CH_HI   = 6'd23;
   localparam logic [5:0] POS_RATE    = 6'd24;
   localparam logic [5:0] POS_BITS_LO = 6'd34;
   localparam logic [5:0] POS_BITS_HI = 6'd35;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  sample_byte;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] riff_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h52;  // R
         2'd1: c = 8'h49;  // I
         2'd2: c = 8'h46;  // F
         default: c = 8'h46;  // F
      endcase
      return c;
   endfunction

   function automatic logic [7:0] wave_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h57;  // W
         2'd1: c = 8'h41;  // A
         2'd2: c = 8'h56;  // V
         default: c = 8'h45;  // E
      endcase
      return c;
   endfunction

   function automatic logic [7:0] fmt_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0: c = 8'h66;  // f
         2'd1: c = 8'h6D;  // m
         default: c = 8'h74;  // t
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ta_char(input logic idx);
      return idx ? 8'h61 : 8'h74;  // t then a
   endfunction

endpackage

/* rtl/wav_header_parser.sv */
// WAV header parser, top level: input register feeding the parse stage.
// Depends on wavhp_pkg, wavhp_in_reg and wavhp_core.
//
// Usage: feed the WAV file one byte per transfer on req_data_byte
// (req_valid / req_stall). The block checks the RIFF/WAVE/fmt tags and PCM
// format, captures channel count, sample rate and bits per sample, finds the
// "data" chunk on byte pairs aligned from offset 36, and reads its size.
// On the rsp_ channel it gives one header result (rsp_kind 0), then one
// sample result (rsp_kind 1) per data byte with rsp_last on the final one
// (or on the header when the size is zero). A failed check gives one error
// result (rsp_kind 2, rsp_error_code) and all later bytes are dropped.
// Bytes past the data chunk are dropped too. Bytes without a result give
// none, but still wait while rsp_stall holds an earlier result.
// A result is registered: the byte sits in the input register, and the
// result register loads when the parse stage takes it from there.
// Throughput: one byte per cycle while rsp_stall holds no result.
// While rsp_stall holds the result, the held byte waits in the input
// register and req_stall rises once that register is full.
// Synchronous reset returns to the header phase and empties both registers.
module wav_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_sample_byte,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_bits_per_sample,
   output logic [31:0] rsp_data_size,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last
);

   logic               take;
   logic               byte_valid;
   logic [7:0]         byte_data;
   wavhp_pkg::rsp_type rsp;

   wavhp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .take          (take),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data)
   );

   wavhp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_sample_byte     = rsp.sample_byte;
   assign rsp_channel_count   = rsp.channel_count;
   assign rsp_sample_rate     = rsp.sample_rate;
   assign rsp_bits_per_sample = rsp.bits_per_sample;
   assign rsp_data_size       = rsp.data_size;
   assign rsp_error_code      = rsp.error_code;
   assign rsp_last            = rsp.last;

endmodule

/* rtl/wavhp_in_reg.sv */
// Input register for the WAV header parser: holds one accepted byte until the
// parse stage takes it. Uses no package items.
module wavhp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       load;

   assign req_stall = valid_ff & ~take;
   assign load      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_data_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

/* rtl/wavhp_core.sv */
// Parse stage and result register of the WAV header parser: phase machine,
// captured header fields, sample countdown. Depends on wavhp_pkg.
module wavhp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         byte_data,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wavhp_pkg::rsp_type rsp
);

   wavhp_pkg::phase_type phase_ff, phase_in;
   logic [5:0]           pos_ff, pos_in;
   logic [7:0]           fmt_lo_ff, fmt_lo_in;
   logic [23:0]          shift_ff, shift_in;
   logic [15:0]          chan_ff, chan_in;
   logic [31:0]          rate_ff, rate_in;
   logic [15:0]          bits_ff, bits_in;
   logic [31:0]          remain_ff, remain_in;
   logic [7:0]           pair_ff, pair_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   wavhp_pkg::rsp_type   rsp_ff, rsp_in;

   logic                 fire;
   logic                 hdr_fail;
   logic [2:0]           hdr_code;
   logic                 ta_fail;
   logic [31:0]          size_word;
   logic                 has_result;
   wavhp_pkg::rsp_type   result;

   assign take = ~rsp_valid_ff | ~rsp_stall;
   assign fire = byte_valid & take;
   assign size_word = {byte_data, shift_ff};
   assign ta_fail = byte_data != wavhp_pkg::ta_char(pos_ff[0]);

   // header tag and format checks
   always_comb begin
      hdr_fail = 1'b0;
      hdr_code = wavhp_pkg::ERR_NOT_RIFF;
      if (pos_ff < 6'd4) begin
         hdr_fail = byte_data != wavhp_pkg::riff_char(pos_ff[1:0]);
         hdr_code = wavhp_pkg::ERR_NOT_RIFF;
      end else if (pos_ff[5:2] == 4'd2) begin
         hdr_fail = byte_data != wavhp_pkg::wave_char(pos_ff[1:0]);
         hdr_code = wavhp_pkg::ERR_NOT_WAVE;
      end else if (pos_ff >= 6'd12 && pos_ff < 6'd15) begin
         hdr_fail = byte_data != wavhp_pkg::fmt_char(pos_ff[1:0]);
         hdr_code = wavhp_pkg::ERR_NOT_FMT;
      end else if (pos_ff == wavhp_pkg::POS_FMT_HI) begin
         hdr_fail = !(fmt_lo_ff == 8'd1 && byte_data == 8'd0);
         hdr_code = wavhp_pkg::ERR_NOT_PCM;
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      fmt_lo_in = fmt_lo_ff;
      shift_in  = shift_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      remain_in = remain_ff;
      pair_in   = pair_ff;
      if (fire) begin
         unique case (phase_ff)
            wavhp_pkg::PH_HEADER: begin
               if (hdr_fail) begin
                  phase_in = wavhp_pkg::PH_ERROR;
               end else begin
                  if (pos_ff == wavhp_pkg::POS_FMT_LO)  fmt_lo_in     = byte_data;
                  if (pos_ff == wavhp_pkg::POS_CH_LO)   chan_in[7:0]  = byte_data;
                  if (pos_ff == wavhp_pkg::POS_CH_HI)   chan_in[15:8] = byte_data;
                  if (pos_ff == wavhp_pkg::POS_BITS_LO) bits_in[7:0]  = byte_data;
                  if (pos_ff == wavhp_pkg::POS_BITS_HI) bits_in[15:8] = byte_data;
                  // bytes 24..27 fill the rate lanes in order
                  if (pos_ff[5:2] == wavhp_pkg::POS_RATE[5:2]) begin
                     rate_in[8*pos_ff[1:0] +: 8] = byte_data;
                  end
                  if (pos_ff >= wavhp_pkg::POS_BITS_HI) begin
                     phase_in = wavhp_pkg::PH_SCAN;
                     pos_in   = 6'd0;
                  end else begin
                     pos_in = pos_ff + 6'd1;
                  end
               end
            end
            wavhp_pkg::PH_SCAN: begin
               if (!pos_ff[0]) begin
                  pair_in = byte_data;
                  pos_in  = 6'd1;
               end else begin
                  pos_in = 6'd0;
                  if (pair_ff == wavhp_pkg::CHAR_D && byte_data == wavhp_pkg::CHAR_A) begin
                     phase_in = wavhp_pkg::PH_TA;
                  end
               end
            end
            wavhp_pkg::PH_TA: begin
               if (ta_fail) begin
                  phase_in = wavhp_pkg::PH_ERROR;
               end else if (pos_ff[0]) begin
                  phase_in = wavhp_pkg::PH_SIZE;
                  pos_in   = 6'd0;
               end else begin
                  pos_in = 6'd1;
               end
            end
            wavhp_pkg::PH_SIZE: begin
               if (pos_ff[1:0] != 2'd3) begin
                  shift_in[8*pos_ff[1:0] +: 8] = byte_data;
                  pos_in = {4'd0, pos_ff[1:0] + 2'd1};
               end else begin
                  pos_in    = 6'd0;
                  remain_in = size_word;
                  phase_in  = (size_word == 32'd0) ? wavhp_pkg::PH_DONE
                                                   : wavhp_pkg::PH_DATA;
               end
            end
            wavhp_pkg::PH_DATA: begin
               if (remain_ff == 32'd0) begin
                  phase_in = wavhp_pkg::PH_DONE;
               end else begin
                  remain_in = remain_ff - 32'd1;
                  if (remain_ff == 32'd1) phase_in = wavhp_pkg::PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result for the byte in hand
   always_comb begin
      has_result = 1'b0;
      result     = '0;
      unique case (phase_ff)
         wavhp_pkg::PH_HEADER: begin
            if (hdr_fail) begin
               has_result        = 1'b1;
               result.kind       = wavhp_pkg::KIND_ERROR;
               result.error_code = hdr_code;
            end
         end
         wavhp_pkg::PH_TA: begin
            if (ta_fail) begin
               has_result        = 1'b1;
               result.kind       = wavhp_pkg::KIND_ERROR;
               result.error_code = wavhp_pkg::ERR_NO_TA;
            end
         end
         wavhp_pkg::PH_SIZE: begin
            if (pos_ff[1:0] == 2'd3) begin
               has_result             = 1'b1;
               result.kind            = wavhp_pkg::KIND_HEADER;
               result.channel_count   = chan_ff;
               result.sample_rate     = rate_ff;
               result.bits_per_sample = bits_ff;
               result.data_size       = size_word;
               result.last            = size_word == 32'd0;
            end
         end
         wavhp_pkg::PH_DATA: begin
            if (remain_ff != 32'd0) begin
               has_result         = 1'b1;
               result.kind        = wavhp_pkg::KIND_SAMPLE;
               result.sample_byte = byte_data;
               result.last        = remain_ff == 32'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = fire & has_result;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wavhp_pkg::PH_HEADER;
         pos_ff       <= '0;
         fmt_lo_ff    <= '0;
         shift_ff     <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         remain_ff    <= '0;
         pair_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         fmt_lo_ff    <= fmt_lo_in;
         shift_ff     <= shift_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         remain_ff    <= remain_in;
         pair_ff      <= pair_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* bench/wavhp_checker.sv */
// Checker for the WAV header parser: watches both channels, predicts each result
// from the accepted bytes and compares field by field. Depends on wavhp_pkg.
module wavhp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_sample_byte,
   input  logic [15:0] rsp_channel_count,
   input  logic [31:0] rsp_sample_rate,
   input  logic [15:0] rsp_bits_per_sample,
   input  logic [31:0] rsp_data_size,
   input  logic [2:0]  rsp_error_code,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] RIFF_WORD = "RIFF";
   localparam logic [31:0] WAVE_WORD = "WAVE";
   localparam logic [23:0] FMT_WORD  = "fmt";
   localparam logic [15:0] TA_WORD   = "ta";

   // parser model state
   wavhp_pkg::phase_type parse_phase;
   logic [5:0]  pos;
   logic [31:0] shift_acc;
   logic [15:0] chan_hold;
   logic [31:0] rate_hold;
   logic [15:0] bits_hold;
   logic [31:0] remaining;
   logic [7:0]  pair_lead;

   wavhp_pkg::rsp_type expected_q[$];

   task automatic report(input string msg);
      if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic push_error(input logic [2:0] code);
      wavhp_pkg::rsp_type r;
      r = '0;
      r.kind = wavhp_pkg::KIND_ERROR;
      r.error_code = code;
      expected_q.push_back(r);
      parse_phase = wavhp_pkg::PH_ERROR;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      int          idx;
      logic        failed;
      logic [2:0]  code;
      logic [1:0]  k;
      wavhp_pkg::rsp_type r;
      idx = int'(pos);
      failed = 1'b0;
      code = wavhp_pkg::ERR_NOT_RIFF;
      r = '0;
      case (parse_phase)
         wavhp_pkg::PH_HEADER: begin
            if (idx < 4) begin
               if (b != RIFF_WORD[8*(3-idx) +: 8]) begin
                  failed = 1'b1;
                  code = wavhp_pkg::ERR_NOT_RIFF;
               end
            end else if (idx >= 8 && idx < 12) begin
               if (b != WAVE_WORD[8*(11-idx) +: 8]) begin
                  failed = 1'b1;
                  code = wavhp_pkg::ERR_NOT_WAVE;
               end
            end else if (idx >= 12 && idx < 15) begin
               if (b != FMT_WORD[8*(14-idx) +: 8]) begin
                  failed = 1'b1;
                  code = wavhp_pkg::ERR_NOT_FMT;
               end
            end else if (idx == 20) begin
               shift_acc = {24'd0, b};
            end else if (idx == 21) begin
               if ((shift_acc | {16'd0, b, 8'd0}) != 32'd1) begin
                  failed = 1'b1;
                  code = wavhp_pkg::ERR_NOT_PCM;
               end
            end else if (idx == 22) begin
               chan_hold = {8'd0, b};
            end else if (idx == 23) begin
               chan_hold = chan_hold | {b, 8'd0};
            end else if (idx >= 24 && idx < 28) begin
               if (idx == 24) rate_hold = '0;
               rate_hold = rate_hold | ({24'd0, b} << (8 * (idx - 24)));
            end else if (idx == 34) begin
               bits_hold = {8'd0, b};
            end else if (idx == 35) begin
               bits_hold = bits_hold | {b, 8'd0};
            end
            if (failed) begin
               push_error(code);
            end else if (idx >= 35) begin
               parse_phase = wavhp_pkg::PH_SCAN;
               pos = '0;
            end else begin
               pos = pos + 6'd1;
            end
         end
         wavhp_pkg::PH_SCAN: begin
            if (!pos[0]) begin
               pair_lead = b;
               pos = 6'd1;
            end else begin
               pos = '0;
               if (pair_lead == wavhp_pkg::CHAR_D && b == wavhp_pkg::CHAR_A)
                  parse_phase = wavhp_pkg::PH_TA;
            end
         end
         wavhp_pkg::PH_TA: begin
            if (b != (pos[0] ? TA_WORD[7:0] : TA_WORD[15:8])) begin
               push_error(wavhp_pkg::ERR_NO_TA);
            end else if (pos[0]) begin
               parse_phase = wavhp_pkg::PH_SIZE;
               pos = '0;
               shift_acc = '0;
            end else begin
               pos = 6'd1;
            end
         end
         wavhp_pkg::PH_SIZE: begin
            k = pos[1:0];
            if (k == 2'd0) shift_acc = '0;
            shift_acc = shift_acc | ({24'd0, b} << (8 * k));
            if (k != 2'd3) begin
               pos = {4'd0, k} + 6'd1;
            end else begin
               pos = '0;
               remaining = shift_acc;
               parse_phase = (remaining == 0) ? wavhp_pkg::PH_DONE : wavhp_pkg::PH_DATA;
               r.kind = wavhp_pkg::KIND_HEADER;
               r.channel_count = chan_hold;
               r.sample_rate = rate_hold;
               r.bits_per_sample = bits_hold;
               r.data_size = shift_acc;
               r.last = (remaining == 0);
               expected_q.push_back(r);
            end
         end
         wavhp_pkg::PH_DATA: begin
            if (remaining == 0) begin
               parse_phase = wavhp_pkg::PH_DONE;
            end else begin
               remaining = remaining - 32'd1;
               if (remaining == 0) parse_phase = wavhp_pkg::PH_DONE;
               r.kind = wavhp_pkg::KIND_SAMPLE;
               r.sample_byte = b;
               r.last = (remaining == 0);
               expected_q.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      wavhp_pkg::rsp_type want;
      if (reset) begin
         parse_phase = wavhp_pkg::PH_HEADER;
         pos = '0;
         shift_acc = '0;
         chan_hold = '0;
         rate_hold = '0;
         bits_hold = '0;
         remaining = '0;
         pair_lead = '0;
         mismatch_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               want = expected_q.pop_front();
               check_field("kind", 32'(rsp_kind), 32'(want.kind));
               check_field("sample_byte", 32'(rsp_sample_byte), 32'(want.sample_byte));
               check_field("channel_count", 32'(rsp_channel_count),
                           32'(want.channel_count));
               check_field("sample_rate", rsp_sample_rate, want.sample_rate);
               check_field("bits_per_sample", 32'(rsp_bits_per_sample),
                           32'(want.bits_per_sample));
               check_field("data_size", rsp_data_size, want.data_size);
               check_field("error_code", 32'(rsp_error_code), 32'(want.error_code));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) predict_byte(req_data_byte);
      end
      outstanding = expected_q.size();
   end

endmodule

/* bench/tb.sv */
// Testbench top for wav_header_parser: builds one WAV byte stream, drives it with
// random gaps and result stalls, and gives the verdict. Depends on wavhp_pkg and wavhp_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT = 1300;
   localparam int QUIET_FROM = ITEM_COUNT * 85 / 100;

   typedef enum int {
      FLAW_NONE,
      FLAW_RIFF,
      FLAW_WAVE,
      FLAW_FMT,
      FLAW_PCM,
      FLAW_TA
   } flaw_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_sample_byte;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_bits_per_sample;
   logic [31:0] rsp_data_size;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;
   int          mismatch_count;
   int          outstanding;

   logic [7:0]  wav_bytes[$];
   logic        quiet;
   int          ta_at;

   wav_header_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_sample_byte     (rsp_sample_byte),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

   wavhp_checker wav_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_sample_byte     (rsp_sample_byte),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic push_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++) wav_bytes.push_back(value[8*i +: 8]);
   endtask

   // zero, all ones or random, so header fields hit their extremes
   function automatic logic [31:0] pick_value(input int nbytes);
      logic [31:0] mask;
      mask = (nbytes == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return mask;
         default: return $urandom & mask;
      endcase
   endfunction

   function automatic logic [7:0] other_than(input logic [7:0] b);
      logic [7:0] v;
      v = 8'($urandom);
      if (v == b) v = b ^ (8'h01 << $urandom_range(0, 7));
      return v;
   endfunction

   task automatic push_junk_pairs();
      logic [7:0] a;
      logic [7:0] b;
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 2))
            0: begin
               // 'd' followed by something other than 'a'
               wav_bytes.push_back(wavhp_pkg::CHAR_D);
               wav_bytes.push_back(other_than(wavhp_pkg::CHAR_A));
            end
            1: begin
               // "da" straddling a pair boundary must not match
               a = 8'($urandom);
               b = 8'($urandom);
               wav_bytes.push_back(a);
               wav_bytes.push_back(wavhp_pkg::CHAR_D);
               wav_bytes.push_back(wavhp_pkg::CHAR_A);
               wav_bytes.push_back(b);
            end
            default: begin
               a = 8'($urandom);
               b = 8'($urandom);
               if (a == wavhp_pkg::CHAR_D && b == wavhp_pkg::CHAR_A) b = b ^ 8'h01;
               wav_bytes.push_back(a);
               wav_bytes.push_back(b);
            end
         endcase
      end
   endtask

   task automatic build_stream();
      flaw_type    flaw;
      int          r;
      int          idx;
      logic [31:0] size;
      int          budget;
      logic [7:0]  lo;
      logic [7:0]  hi;
      r = $urandom_range(0, 15);
      if (r < 10) flaw = FLAW_NONE;
      else if (r == 10) flaw = FLAW_RIFF;
      else if (r == 11) flaw = FLAW_WAVE;
      else if (r == 12) flaw = FLAW_FMT;
      else if (r == 13) flaw = FLAW_PCM;
      else flaw = FLAW_TA;

      push_le({8'h46, 8'h46, 8'h49, 8'h52}, 4);   // RIFF
      push_le($urandom, 4);
      push_le({8'h45, 8'h56, 8'h41, 8'h57}, 4);   // WAVE
      push_le({8'h00, 8'h74, 8'h6D, 8'h66}, 3);   // fmt
      wav_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom));
      push_le($urandom, 4);
      push_le(32'd1, 2);
      push_le(pick_value(2), 2);
      push_le(pick_value(4), 4);
      push_le($urandom, 4);
      push_le($urandom, 2);
      push_le(pick_value(2), 2);

      push_junk_pairs();
      wav_bytes.push_back(wavhp_pkg::CHAR_D);
      wav_bytes.push_back(wavhp_pkg::CHAR_A);
      ta_at = wav_bytes.size();
      wav_bytes.push_back(8'h74);
      wav_bytes.push_back(8'h61);

      case ($urandom_range(0, 7))
         0: size = 32'd0;
         1: size = 32'd1;
         2: size = 32'hFFFF_FFFF;
         3: size = $urandom | 32'h8000_0000;
         default: size = $urandom_range(2, 1100);
      endcase
      push_le(size, 4);
      budget = ITEM_COUNT - wav_bytes.size();
      if (size < budget) budget = size;
      repeat (budget) wav_bytes.push_back(8'($urandom));
      while (wav_bytes.size() < ITEM_COUNT) wav_bytes.push_back(8'($urandom));

      case (flaw)
         FLAW_RIFF: begin
            idx = $urandom_range(0, 3);
            wav_bytes[idx] = other_than(wav_bytes[idx]);
         end
         FLAW_WAVE: begin
            idx = $urandom_range(8, 11);
            wav_bytes[idx] = other_than(wav_bytes[idx]);
         end
         FLAW_FMT: begin
            idx = $urandom_range(12, 14);
            wav_bytes[idx] = other_than(wav_bytes[idx]);
         end
         FLAW_PCM: begin
            lo = 8'($urandom);
            hi = 8'($urandom);
            if (lo == 8'h01 && hi == 8'h00) hi = 8'h01;
            wav_bytes[20] = lo;
            wav_bytes[21] = hi;
         end
         FLAW_TA: begin
            idx = ta_at + $urandom_range(0, 1);
            wav_bytes[idx] = other_than(wav_bytes[idx]);
         end
         default: ;
      endcase
   endtask

   // result-side stall bursts; rate changes now and then, zero gives calm stretches
   initial begin
      int stall_left;
      int stall_odds;
      int cycle_n;
      stall_left = 0;
      stall_odds = 0;
      cycle_n = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_n % 128 == 0) stall_odds = $urandom_range(0, 2) * 5;
         cycle_n++;
         if (stall_left != 0) stall_left--;
         else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            stall_left = $urandom_range(1, 7);
         rsp_stall = (stall_left != 0) && !quiet;
      end
   end

   initial begin
      int gap_odds;
      int waited;
      quiet = 1'b0;
      gap_odds = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      build_stream();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < wav_bytes.size(); i++) begin
         if (i % 100 == 0) gap_odds = $urandom_range(0, 2) * 5;
         if (i >= QUIET_FROM) quiet = 1'b1;
         if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         req_valid = 1'b1;
         req_data_byte = wav_bytes[i];
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid = 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
